>>> rtl/mfde_pkg.sv
// Package for the one-bit-per-pixel framebuffer draw engine.
// Holds the command and result payload types, register indexes and the
// control and status structs shared by the controller and the datapath.
package mfde_pkg;

  localparam int CFG_W  = 9;
  localparam int HGT_W  = 8;
  localparam int RB_W   = 7;
  localparam int IDX_W  = 24;
  localparam int LEN_W  = 16;
  localparam int COORD_W = 16;
  localparam int CLAMP_W = 13;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 8'd128;
  localparam logic [7:0]       BYTE_ONES    = 8'hFF;
  localparam logic [7:0]       MSB_MASK     = 8'h80;

  typedef enum logic [2:0] {
    OP_SET  = 3'd0,
    OP_CLR  = 3'd1,
    OP_GET  = 3'd2,
    OP_LINE = 3'd3,
    OP_FILL = 3'd4,
    OP_INV  = 3'd5
  } op_t;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    WS_ZERO = 3'd0,
    WS_FILL = 3'd1,
    WS_SET  = 3'd2,
    WS_CLR  = 3'd3,
    WS_INV  = 3'd4
  } wsrc_t;

  typedef struct packed {
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LEN_W-1:0]   length;
    logic               fill_ones;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic pixel;
  } res_t;

  typedef struct packed {
    logic  latch;
    logic  calc;
    logic  rd;
    logic  wr;
    wsrc_t wsrc;
    logic  use_ptr;
    logic  ptr_inc;
    logic  line_step;
    logic  res_ok;
    logic  res_pix;
  } dp_ctrl_t;

  typedef struct packed {
    op_t  op;
    logic in_range;
    logic len_zero;
    logic line_last;
    logic ptr_last;
    logic clr_last;
  } dp_stat_t;

endpackage

>>> rtl/mono_framebuffer_draw_engine_top.sv
// Top level of the one-bit-per-pixel framebuffer draw engine.
// Depends on mfde_pkg, mfde_ctrl and mfde_datapath.
//
// A command is transferred when start is high and busy is low. Each command
// gives exactly one result, shown on result for the single cycle in which
// done is high; the receiver cannot hold it off. Pixels are packed MSB-first,
// row stride ceil(width/8) bytes, store of ceil(MAX_WIDTH/8)*MAX_HEIGHT bytes
// in one single-port memory with a registered read.
// After transfer the address is formed. Set, clear and get then read the byte
// and write it back or sample it, ending without a read when the pixel lies
// outside the frame. Unused op codes and zero-length lines end at that step.
// A vertical line reads and writes one byte per pixel and ends early if it
// leaves the frame; fill writes and invert reads and rewrites each active byte.
// The next command can be transferred in the done cycle itself.
// Configuration writes (width, height) go through registers and must be made
// while the block is idle and before the next command is transferred.
// After reset a clearing pass writes zero to all ceil(MAX_WIDTH/8)*MAX_HEIGHT
// bytes of the store, 4096 at the default size, during which busy stays high.
module mono_framebuffer_draw_engine_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  mfde_pkg::cfg_idx_t         cfg_index,
  input  logic [mfde_pkg::CFG_W-1:0] cfg_data,
  input  logic                       start,
  input  mfde_pkg::cmd_t             cmd,
  output logic                       busy,
  output logic                       done,
  output mfde_pkg::res_t             result
);
  import mfde_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  mfde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  mfde_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .ctrl      (ctrl),
    .stat      (stat),
    .result    (result)
  );

endmodule

>>> rtl/mfde_datapath.sv
// Datapath of the framebuffer draw engine: configuration registers, the
// byte store, address arithmetic, sweep pointer and result register.
// Depends on mfde_pkg; driven by mfde_ctrl through dp_ctrl_t.
module mfde_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  mfde_pkg::cfg_idx_t      cfg_index,
  input  logic [mfde_pkg::CFG_W-1:0] cfg_data,
  input  mfde_pkg::cmd_t          cmd,
  input  mfde_pkg::dp_ctrl_t      ctrl,
  output mfde_pkg::dp_stat_t      stat,
  output mfde_pkg::res_t          result
);
  import mfde_pkg::*;

  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int STORE_BYTES   = ROW_BYTES_MAX * MAX_HEIGHT;
  localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int ACT_W         = $clog2(STORE_BYTES + 1);

  logic [CFG_W-1:0]   width_reg;
  logic [HGT_W-1:0]   height_reg;
  logic [RB_W-1:0]    rb;
  logic [ACT_W-1:0]   active;
  cmd_t               cmd_q;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   rem;
  logic [ADDR_W-1:0]  ptr;
  logic [7:0]         rdata;
  logic [7:0]         wdata;
  logic [7:0]         mask;
  logic [ADDR_W-1:0]  addr;
  logic [7:0]         mem [STORE_BYTES];

  logic [CLAMP_W-1:0] w_ext;
  logic [CLAMP_W-1:0] w_clamp;
  logic [CLAMP_W-1:0] h_ext;
  logic [CLAMP_W-1:0] h_clamp;
  logic [14:0]        act_full;

  always_comb begin
    w_ext = CLAMP_W'(width_reg);
    h_ext = CLAMP_W'(height_reg);
    if (w_ext == '0) begin
      w_clamp = CLAMP_W'(1);
    end else if (w_ext > CLAMP_W'(MAX_WIDTH)) begin
      w_clamp = CLAMP_W'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (h_ext == '0) begin
      h_clamp = CLAMP_W'(1);
    end else if (h_ext > CLAMP_W'(MAX_HEIGHT)) begin
      h_clamp = CLAMP_W'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    act_full = 15'(h_clamp[HGT_W-1:0]) * 15'(rb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_reg  <= cfg_data;
        CFG_HEIGHT: height_reg <= cfg_data[HGT_W-1:0];
        default:    width_reg  <= width_reg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rb     <= RB_W'((w_clamp + CLAMP_W'(7)) >> 3);
    active <= ACT_W'(act_full);
  end

  assign mask = MSB_MASK >> cmd_q.x[2:0];
  assign addr = ctrl.use_ptr ? ptr : idx[ADDR_W-1:0];

  always_comb begin
    unique case (ctrl.wsrc)
      WS_ZERO: wdata = '0;
      WS_FILL: wdata = cmd_q.fill_ones ? BYTE_ONES : 8'h00;
      WS_SET:  wdata = rdata | mask;
      WS_CLR:  wdata = rdata & ~mask;
      WS_INV:  wdata = ~rdata;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_q <= cmd;
    end
    if (ctrl.calc) begin
      idx <= IDX_W'(cmd_q.x >> 3) + IDX_W'(cmd_q.y) * IDX_W'(rb);
    end else if (ctrl.line_step) begin
      idx <= idx + IDX_W'(rb);
    end
    if (ctrl.latch) begin
      rem <= cmd.length;
    end else if (ctrl.line_step) begin
      rem <= rem - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (ctrl.latch) begin
      ptr <= '0;
    end else if (ctrl.ptr_inc) begin
      ptr <= ptr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result <= '0;
    end else if (ctrl.latch) begin
      result <= '0;
    end else begin
      if (ctrl.res_ok) begin
        result.ok <= 1'b1;
      end
      if (ctrl.res_pix) begin
        result.pixel <= |(rdata & mask);
      end
    end
  end

  always_comb begin
    stat.op        = cmd_q.op;
    stat.in_range  = idx < IDX_W'(active);
    stat.len_zero  = cmd_q.length == '0;
    stat.line_last = rem == LEN_W'(1);
    stat.ptr_last  = (ACT_W'(ptr) + ACT_W'(1)) == active;
    stat.clr_last  = ptr == ADDR_W'(STORE_BYTES - 1);
  end

endmodule

>>> rtl/mfde_ctrl.sv
// Controller of the framebuffer draw engine: sequences the clearing pass,
// pixel read-modify-write, line walk, fill and invert sweeps.
// Depends on mfde_pkg; commands mfde_datapath through dp_ctrl_t.
module mfde_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mfde_pkg::dp_stat_t  stat,
  output mfde_pkg::dp_ctrl_t  ctrl,
  output logic                busy,
  output logic                done
);
  import mfde_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_PIX_RD,
    S_PIX_WR,
    S_LINE_RD,
    S_LINE_WR,
    S_FILL,
    S_INV_RD,
    S_INV_WR
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
      done  <= done_next;
    end
  end

  always_comb begin
    ctrl       = '0;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ctrl.wr      = 1'b1;
        ctrl.wsrc    = WS_ZERO;
        ctrl.use_ptr = 1'b1;
        ctrl.ptr_inc = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl.latch = 1'b1;
          state_next = S_ADDR;
        end
      end
      S_ADDR: begin
        ctrl.calc = 1'b1;
        unique case (stat.op)
          OP_SET, OP_CLR, OP_GET: state_next = S_PIX_RD;
          OP_LINE: begin
            if (stat.len_zero) begin
              ctrl.res_ok = 1'b1;
              done_next   = 1'b1;
              state_next  = S_IDLE;
            end else begin
              state_next = S_LINE_RD;
            end
          end
          OP_FILL: state_next = S_FILL;
          OP_INV:  state_next = S_INV_RD;
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_PIX_RD: begin
        if (stat.in_range) begin
          ctrl.rd    = 1'b1;
          state_next = S_PIX_WR;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_PIX_WR: begin
        ctrl.res_ok = 1'b1;
        done_next   = 1'b1;
        state_next  = S_IDLE;
        if (stat.op == OP_SET) begin
          ctrl.wr   = 1'b1;
          ctrl.wsrc = WS_SET;
        end else if (stat.op == OP_CLR) begin
          ctrl.wr   = 1'b1;
          ctrl.wsrc = WS_CLR;
        end else begin
          ctrl.res_pix = 1'b1;
        end
      end
      S_LINE_RD: begin
        if (stat.in_range) begin
          ctrl.rd    = 1'b1;
          state_next = S_LINE_WR;
        end else begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINE_WR: begin
        ctrl.wr        = 1'b1;
        ctrl.wsrc      = WS_SET;
        ctrl.line_step = 1'b1;
        if (stat.line_last) begin
          ctrl.res_ok = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_LINE_RD;
        end
      end
      S_FILL: begin
        ctrl.wr      = 1'b1;
        ctrl.wsrc    = WS_FILL;
        ctrl.use_ptr = 1'b1;
        ctrl.ptr_inc = 1'b1;
        if (stat.ptr_last) begin
          ctrl.res_ok = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_INV_RD: begin
        ctrl.rd      = 1'b1;
        ctrl.use_ptr = 1'b1;
        state_next   = S_INV_WR;
      end
      S_INV_WR: begin
        ctrl.wr      = 1'b1;
        ctrl.wsrc    = WS_INV;
        ctrl.use_ptr = 1'b1;
        ctrl.ptr_inc = 1'b1;
        if (stat.ptr_last) begin
          ctrl.res_ok = 1'b1;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          state_next = S_INV_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/mfde_checker.sv
// Port-level checker for the framebuffer draw engine, bound to the top level.
// Depends on mfde_pkg and mono_framebuffer_draw_engine_top.
module mfde_port_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input mfde_pkg::res_t result
);
  import mfde_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy did not rise after a command transfer");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result shown without a command in progress");

  a_pixel_needs_ok: assert property (@(posedge clk) disable iff (rst)
    done && result.pixel |-> result.ok)
    else $error("pixel reported on a failed command");

endmodule

bind mono_framebuffer_draw_engine_top mfde_port_checker u_mfde_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
